@@ rtl/core/ldsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ldsc_pkg
// Shared types, constants and helpers of the line deframer with sum checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package ldsc_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned WinDepth     = 4;
   localparam int unsigned FillWidth    = 3;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 8;
   localparam int unsigned StatusWidth  = 3;
   localparam int unsigned QueueDepth   = 4;

   localparam logic [ByteWidth-1:0] CrByte        = 8'd13;
   localparam logic [ByteWidth-1:0] TermResetByte = 8'd10;
   localparam logic [ByteWidth-1:0] SepResetByte  = 8'd58;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TERMINATOR = 2'd0,
      CSR_SEPARATOR  = 2'd1,
      CSR_STRIP_CR   = 2'd2
   } csr_index_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_SEP   = 3'd2,
      ST_HEX   = 3'd3,
      ST_CSUM  = 3'd4
   } status_type;

   // one queue entry: up to one payload word followed by up to one verdict word
   typedef struct packed {
      logic                 pay_vld;
      logic [ByteWidth-1:0] pay_byte;
      logic                 end_vld;
      status_type           status;
   } entry_type;

   // bit 4 set when the byte is a hex digit, bits 3:0 its value
   function automatic logic [4:0] hex_decode(input logic [ByteWidth-1:0] c);
      logic [4:0] res;
      res = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         res = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         res = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         res = {1'b1, 4'(c - 8'h37)};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/ldsc_front.sv @@
// ----------------------------------------------------------------------------
// ldsc_front
// Accepts received words, keeps the line window and sum, classifies each word
// and pushes the resulting payload and verdict words into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ldsc_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [ldsc_pkg::ByteWidth-1:0]   req_rx_byte,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [ldsc_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire  [ldsc_pkg::CsrDataWidth-1:0] csr_wdata,
   input  wire                              q_ready,
   output logic                             q_push,
   output ldsc_pkg::entry_type              q_entry
);
   import ldsc_pkg::*;

   logic [ByteWidth-1:0]                term_ff, sep_ff;
   logic                                strip_ff;
   logic [WinDepth-1:0][ByteWidth-1:0]  win_ff, win_in;
   logic [FillWidth-1:0]                fill_ff, fill_in;
   logic [ByteWidth-1:0]                sum_ff, sum_in;
   logic                                nonempty_ff, nonempty_in;

   logic                 accept;
   logic [1:0]           last_idx;
   logic [FillWidth-1:0] n_tail;
   logic [ByteWidth-1:0] chk_sum;
   logic [ByteWidth-1:0] t_sep, t_hi, t_lo;
   logic [4:0]           hx_hi, hx_lo;
   entry_type            ent;
   logic                 push;

   assign req_ready = q_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign q_push    = push;
   assign q_entry   = ent;

   always_comb begin
      win_in      = win_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      nonempty_in = nonempty_ff;
      ent         = '{pay_vld: 1'b0, pay_byte: '0, end_vld: 1'b0, status: ST_OK};
      push        = 1'b0;
      last_idx    = 2'(fill_ff - 3'd1);
      n_tail      = fill_ff;
      chk_sum     = sum_ff;
      t_sep       = win_ff[0];
      t_hi        = win_ff[1];
      t_lo        = win_ff[2];
      hx_hi       = hex_decode(t_hi);
      hx_lo       = hex_decode(t_lo);

      if (strip_ff && fill_ff != '0 && win_ff[last_idx] == CrByte) begin
         n_tail = fill_ff - 3'd1;
      end
      if (n_tail == 3'(WinDepth)) begin
         chk_sum = sum_ff + win_ff[0];
         t_sep   = win_ff[1];
         t_hi    = win_ff[2];
         t_lo    = win_ff[3];
         hx_hi   = hex_decode(t_hi);
         hx_lo   = hex_decode(t_lo);
      end

      if (accept) begin
         if (req_rx_byte != term_ff) begin
            nonempty_in = 1'b1;
            if (fill_ff == 3'(WinDepth)) begin
               push         = 1'b1;
               ent.pay_vld  = 1'b1;
               ent.pay_byte = win_ff[0];
               sum_in       = sum_ff + win_ff[0];
               win_in       = {req_rx_byte, win_ff[3], win_ff[2], win_ff[1]};
            end else begin
               win_in[fill_ff[1:0]] = req_rx_byte;
               fill_in              = fill_ff + 3'd1;
            end
         end else begin
            push        = 1'b1;
            ent.end_vld = 1'b1;
            if (fill_ff == '0 && !nonempty_ff) begin
               ent.status = ST_EMPTY;
            end else begin
               if (n_tail == 3'(WinDepth)) begin
                  ent.pay_vld  = 1'b1;
                  ent.pay_byte = win_ff[0];
               end
               if (n_tail < 3'd3 || t_sep != sep_ff || t_hi == sep_ff || t_lo == sep_ff) begin
                  ent.status = ST_SEP;
               end else if (!hx_hi[4] || !hx_lo[4]) begin
                  ent.status = ST_HEX;
               end else if ({hx_hi[3:0], hx_lo[3:0]} != chk_sum) begin
                  ent.status = ST_CSUM;
               end else begin
                  ent.status = ST_OK;
               end
            end
            win_in      = '0;
            fill_in     = '0;
            sum_in      = '0;
            nonempty_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff     <= TermResetByte;
         sep_ff      <= SepResetByte;
         strip_ff    <= 1'b1;
         win_ff      <= '0;
         fill_ff     <= '0;
         sum_ff      <= '0;
         nonempty_ff <= 1'b0;
      end else begin
         win_ff      <= win_in;
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
         nonempty_ff <= nonempty_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_TERMINATOR: term_ff  <= csr_wdata[ByteWidth-1:0];
               CSR_SEPARATOR:  sep_ff   <= csr_wdata[ByteWidth-1:0];
               CSR_STRIP_CR:   strip_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/ldsc_queue.sv @@
// ----------------------------------------------------------------------------
// ldsc_queue
// Short first-in first-out queue of entries between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ldsc_queue #(
   parameter int unsigned DEPTH = ldsc_pkg::QueueDepth
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  ldsc_pkg::entry_type  push_entry,
   output logic                 push_ready,
   input  wire                  pop,
   output logic                 head_valid,
   output ldsc_pkg::entry_type  head_entry
);
   import ldsc_pkg::*;

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);

   entry_type             mem [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0]   count_ff;
   logic                  do_push, do_pop;

   assign push_ready = count_ff != CntWidth'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = mem[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] p);
      return (p == PtrWidth'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/ldsc_back.sv @@
// ----------------------------------------------------------------------------
// ldsc_back
// Takes queue entries and sends their payload and verdict words one per cycle,
// while the receiver is ready, through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ldsc_back (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                head_valid,
   input  ldsc_pkg::entry_type                head_entry,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [ldsc_pkg::ByteWidth-1:0]     rsp_payload_byte,
   output logic                               rsp_line_end,
   output logic [ldsc_pkg::StatusWidth-1:0]   rsp_line_status
);
   import ldsc_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 phase_ff, phase_in;
   logic [ByteWidth-1:0] pay_ff, pay_in;
   logic                 end_ff, end_in;
   status_type           status_ff, status_in;
   logic                 load;

   assign load = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in  = valid_ff;
      phase_in  = phase_ff;
      pay_in    = pay_ff;
      end_in    = end_ff;
      status_in = status_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (!phase_ff && head_entry.pay_vld) begin
            pay_in    = head_entry.pay_byte;
            end_in    = 1'b0;
            status_in = ST_OK;
            if (head_entry.end_vld) begin
               phase_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            pay_in    = '0;
            end_in    = 1'b1;
            status_in = head_entry.status;
            phase_in  = 1'b0;
            pop       = 1'b1;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
      pay_ff    <= pay_in;
      end_ff    <= end_in;
      status_ff <= status_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_payload_byte = pay_ff;
   assign rsp_line_end     = end_ff;
   assign rsp_line_status  = status_ff;

endmodule

`default_nettype wire

@@ rtl/core/line_deframer_sum_checksum_top.sv @@
// ----------------------------------------------------------------------------
// line_deframer_sum_checksum_top
// Splits received words into lines and checks the two-digit hex sum tail.
//
// Input channel req_: one received word per accepted handshake, up to one
// per cycle; req_ready drops only while the internal queue is full.
// Result channel rsp_: payload words of the line, each with line_end low,
// and one verdict word per terminator with line_end high and line_status
// (ok, empty, separator misplaced, bad hex, checksum mismatch).
// Payload words leave once four newer words of the line are held, so the
// checksum tail can be checked when the terminator arrives.
// Configuration csr_: index 0 terminator, 1 separator, 2 strip_cr (bit 0);
// other indexes are ignored; csr_ready is always high.
// A result is registered in the queue and then in the output register
// before it is valid on rsp_. One word in per cycle while the queue has
// room, and one result out per cycle while the receiver is ready.
// Reset clears the line window, sum, queue and output register and loads
// the default configuration. When the receiver stalls, results wait in the
// output register and the queue, and the input stalls only once it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module line_deframer_sum_checksum_top #(
   parameter int unsigned QUEUE_DEPTH = ldsc_pkg::QueueDepth
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [ldsc_pkg::ByteWidth-1:0]      req_rx_byte,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [ldsc_pkg::ByteWidth-1:0]      rsp_payload_byte,
   output logic                                rsp_line_end,
   output logic [ldsc_pkg::StatusWidth-1:0]    rsp_line_status,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [ldsc_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire  [ldsc_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import ldsc_pkg::*;

   logic      q_push, q_ready, q_pop, q_head_valid;
   entry_type q_entry, q_head;

   ldsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   ldsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   ldsc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_head_valid),
      .head_entry       (q_head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_line_end     (rsp_line_end),
      .rsp_line_status  (rsp_line_status)
   );

endmodule

`default_nettype wire

@@ tb/tb_line_deframer_sum_checksum_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_deframer_sum_checksum_top
// Self-checking bench for the line deframer with additive hex checksum.
// Feeds received words, directed first and then random lines (well-formed,
// corrupted and noise), under several terminator, separator and CR settings.
// A local model of the holding window predicts every payload and verdict
// word, and a monitor compares each result word against it. Both channels
// idle and stall in random bursts.
// ----------------------------------------------------------------------------

module tb_line_deframer_sum_checksum_top;
   import ldsc_pkg::*;

   localparam logic [CsrIdxWidth-1:0] CsrIdxSpare = 2'd3;
   localparam int WatchdogLimit = 2000;
   localparam int SettleCycles  = 8;

   typedef struct {
      logic [ByteWidth-1:0] payload;
      logic                 line_end;
      status_type           status;
   } line_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   logic [ByteWidth-1:0]    req_rx_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   logic [ByteWidth-1:0]    rsp_payload_byte;
   logic                    rsp_line_end;
   logic [StatusWidth-1:0]  rsp_line_status;
   logic                    csr_valid   = 1'b0;
   logic                    csr_ready;
   logic [CsrIdxWidth-1:0]  csr_index   = '0;
   logic [CsrDataWidth-1:0] csr_wdata   = '0;

   // model of the block
   logic [ByteWidth-1:0] term_cfg  = TermResetByte;
   logic [ByteWidth-1:0] sep_cfg   = SepResetByte;
   logic                 strip_cfg = 1'b1;
   logic [ByteWidth-1:0] held [WinDepth];
   int unsigned          held_count = 0;
   logic [ByteWidth-1:0] line_sum   = '0;
   logic                 line_seen  = 1'b0;

   line_word_type        expected_words [$];
   logic [ByteWidth-1:0] pending_bytes [$];
   line_word_type        due_word;

   int error_count  = 0;
   int gap_odds     = 0;
   int send_gap     = 0;
   int hold_gap     = 0;
   int stall_cycles = 0;
   logic [ByteWidth-1:0] pick_term, pick_sep;

   line_deframer_sum_checksum_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_line_end     (rsp_line_end),
      .rsp_line_status  (rsp_line_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void add_pending(input logic [ByteWidth-1:0] b);
      pending_bytes.insert(pending_bytes.size(), b);
   endfunction

   function automatic void add_expected(input logic [ByteWidth-1:0] pay,
                                        input logic fin,
                                        input status_type st);
      line_word_type w;
      w.payload  = pay;
      w.line_end = fin;
      w.status   = st;
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic int digit_value(input logic [ByteWidth-1:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic logic [ByteWidth-1:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + nib;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
   endfunction

   // advances the window model by one received word
   function automatic void deframe_byte(input logic [ByteWidth-1:0] rx);
      int unsigned          n;
      int                   i, hi, lo;
      logic [ByteWidth-1:0] sum;
      status_type           verdict;
      if (rx != term_cfg) begin
         if (held_count == WinDepth) begin
            add_expected(held[0], 1'b0, ST_OK);
            line_sum += held[0];
            for (i = 0; i < WinDepth - 1; i++) held[i] = held[i + 1];
            held_count = WinDepth - 1;
         end
         held[held_count] = rx;
         held_count++;
         line_seen = 1'b1;
         return;
      end
      n   = held_count;
      sum = line_sum;
      if (n == 0 && !line_seen) begin
         verdict = ST_EMPTY;
      end else begin
         if (strip_cfg && n > 0 && held[n - 1] == CrByte) n--;
         if (n == WinDepth) begin
            add_expected(held[0], 1'b0, ST_OK);
            sum += held[0];
         end
         if (n < 3) begin
            verdict = ST_SEP;
         end else if (held[n - 3] != sep_cfg || held[n - 2] == sep_cfg ||
                      held[n - 1] == sep_cfg) begin
            verdict = ST_SEP;
         end else begin
            hi = digit_value(held[n - 2]);
            lo = digit_value(held[n - 1]);
            if (hi < 0 || lo < 0) verdict = ST_HEX;
            else if (8'(hi * 16 + lo) != sum) verdict = ST_CSUM;
            else verdict = ST_OK;
         end
      end
      add_expected(8'd0, 1'b1, verdict);
      for (i = 0; i < WinDepth; i++) held[i] = '0;
      held_count = 0;
      line_sum   = '0;
      line_seen  = 1'b0;
   endfunction

   task automatic csr_write(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TERMINATOR: term_cfg = data;
         CSR_SEPARATOR:  sep_cfg = data;
         CSR_STRIP_CR:   strip_cfg = data[0];
         default: ;
      endcase
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) add_pending(s[i]);
   endtask

   task automatic queue_random_line();
      logic [ByteWidth-1:0] line [$];
      logic [ByteWidth-1:0] sum, b;
      int len, kind, i;
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      sum  = '0;
      for (i = 0; i < len; i++) begin
         do b = 8'($urandom_range(0, 255)); while (b == term_cfg);
         line.insert(line.size(), b);
         sum += b;
      end
      if (kind < 80) begin
         if (kind >= 60 && kind < 70) sum += 8'($urandom_range(1, 255));
         line.insert(line.size(), sep_cfg);
         line.insert(line.size(), hex_char(sum[7:4]));
         line.insert(line.size(), hex_char(sum[3:0]));
         if (kind >= 70 && kind < 75) begin
            do b = 8'($urandom_range(0, 255)); while (b == term_cfg);
            line[$urandom_range(0, line.size() - 1)] = b;
         end else if (kind >= 75) begin
            line.delete($urandom_range(0, line.size() - 1));
         end
         if (CrByte != term_cfg && $urandom_range(0, 99) < (strip_cfg ? 40 : 5))
            line.insert(line.size(), CrByte);
      end else if (kind < 85) begin
         line.delete();
      end else if (kind < 90) begin
         line.delete();
         if (CrByte != term_cfg) line.insert(line.size(), CrByte);
      end else begin
         // noise, sometimes with a separator near the end
         if ($urandom_range(0, 1)) line.insert(line.size(), sep_cfg);
         for (i = $urandom_range(0, 3); i > 0; i--) begin
            do b = 8'($urandom_range(0, 255)); while (b == term_cfg);
            line.insert(line.size(), b);
         end
      end
      foreach (line[j]) add_pending(line[j]);
      add_pending(term_cfg);
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_words.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic run_phase(input int n_bytes, input int odds);
      int half;
      gap_odds = odds;
      @(negedge clock);
      half = n_bytes / 2;
      while (pending_bytes.size() < half) queue_random_line();
      // hold off until the block has drained
      wait_drained();
      while (pending_bytes.size() < n_bytes - half) queue_random_line();
      wait_drained();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) deframe_byte(req_rx_byte);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0 && gap_odds != 0 &&
                         $urandom_range(1, gap_odds) == 1) begin
               send_gap  <= $urandom_range(0, 15);
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: payload_byte %0d line_end %0d line_status %0d",
                      rsp_payload_byte, rsp_line_end, rsp_line_status);
               error_count++;
            end else begin
               due_word = expected_words.pop_front();
               if (rsp_payload_byte !== due_word.payload) begin
                  $error("payload_byte: expected %0d, got %0d",
                         due_word.payload, rsp_payload_byte);
                  error_count++;
               end
               if (rsp_line_end !== due_word.line_end) begin
                  $error("line_end: expected %0d, got %0d", due_word.line_end, rsp_line_end);
                  error_count++;
               end
               if (rsp_line_status !== due_word.status) begin
                  $error("line_status: expected %0d, got %0d",
                         due_word.status, rsp_line_status);
                  error_count++;
               end
            end
         end
         if (hold_gap > 0) begin
            hold_gap  <= hold_gap - 1;
            rsp_ready <= 1'b0;
         end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            hold_gap  <= $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < WinDepth; i++) held[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty line, lone cr, extreme bytes with lower-case digits
      add_pending(term_cfg);
      add_pending(CrByte);
      add_pending(term_cfg);
      add_pending(8'h00);
      add_pending(8'hFF);
      queue_text(":ff");
      add_pending(CrByte);
      add_pending(term_cfg);
      // bad hex, mismatch, separator in digit position, short tail
      queue_text(":0g");
      add_pending(term_cfg);
      queue_text(":0A");
      add_pending(term_cfg);
      queue_text("::0");
      add_pending(term_cfg);
      queue_text("5");
      add_pending(term_cfg);
      run_phase(260, 12);

      csr_write(CSR_TERMINATOR, 8'h00);
      csr_write(CSR_SEPARATOR, 8'hFF);
      csr_write(CSR_STRIP_CR, 8'hFE);
      run_phase(260, 6);

      csr_write(CsrIdxSpare, 8'($urandom_range(0, 255)));
      csr_write(CSR_TERMINATOR, 8'hFF);
      csr_write(CSR_SEPARATOR, 8'h00);
      csr_write(CSR_STRIP_CR, 8'h01);
      csr_write(CsrIdxSpare, 8'($urandom_range(0, 255)));
      run_phase(260, 20);

      // terminator equal to separator
      csr_write(CSR_TERMINATOR, 8'h3B);
      csr_write(CSR_SEPARATOR, 8'h3B);
      run_phase(160, 10);

      do pick_term = 8'($urandom_range(0, 255));
      while (digit_value(pick_term) >= 0 || pick_term == CrByte);
      do pick_sep = 8'($urandom_range(0, 255));
      while (digit_value(pick_sep) >= 0 || pick_sep == CrByte || pick_sep == pick_term);
      csr_write(CSR_TERMINATOR, pick_term);
      csr_write(CSR_SEPARATOR, pick_sep);
      csr_write(CSR_STRIP_CR, 8'($urandom_range(0, 255)));
      run_phase(300, 8);

      csr_write(CSR_TERMINATOR, TermResetByte);
      csr_write(CSR_SEPARATOR, SepResetByte);
      csr_write(CSR_STRIP_CR, 8'h01);
      run_phase(300, 0);

      if (expected_words.size() != 0) begin
         $error("%0d expected words never arrived", expected_words.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
